[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH        = 16;
  localparam int SCORE_BITS   = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int CNT_BITS     = $clog2(DEPTH + 1);
  localparam int COUNT_W      = 5;
  localparam int STATUS_W     = 2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [SCORE_BITS-1:0]   score;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

[rtl/core/spq_if.sv]
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels for operations and results of the priority queue.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [spq_pkg::SCORE_BITS-1:0]   new_score;
  logic [spq_pkg::PAYLOAD_BITS-1:0] new_payload;

  modport source (output valid, func, new_score, new_payload, input ready);
  modport sink   (input valid, func, new_score, new_payload, output ready);
endinterface

interface spq_out_if;
  logic                             valid;
  logic                             ready;
  logic [spq_pkg::SCORE_BITS-1:0]   out_score;
  logic [spq_pkg::PAYLOAD_BITS-1:0] out_payload;
  logic [spq_pkg::STATUS_W-1:0]     status;
  logic [spq_pkg::COUNT_W-1:0]      count;

  modport source (output valid, out_score, out_payload, status, count, input ready);
  modport sink   (input valid, out_score, out_payload, status, count, output ready);
endinterface

[rtl/core/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and shifts with its neighbours.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  spq_pkg::entry_t     new_entry,
  input  spq_pkg::entry_t     left_entry,
  input  logic                left_lt,
  input  spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t     entry,
  output logic                lt
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // An empty slot counts as lower than any new entry, so the new entry lands
  // at the first slot that is lower or empty.
  assign lt = !occ || (entry_r.score < new_entry.score);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.rem) begin
      entry_nxt = right_entry;
    end else if (ctrl.ins && lt) begin
      entry_nxt = left_lt ? left_entry : new_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

[rtl/core/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue kept sorted by descending score in a chain of shift cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  in_ch    sink       func, new_score, new_payload
//  out_ch   source     out_score, out_payload, status, count
//
//  Every cell compares and shifts in parallel in the cycle of the transfer, and
//  the result appears in the output register on the next cycle. A new
//  operation is taken every cycle while the output register is empty or being
//  drained. Reset empties the queue at once; the cell contents are left as
//  they are. A stalled result holds the input off.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic             clk,
  input  logic             rst_n,
  spq_in_if.sink           in_ch,
  spq_out_if.source        out_ch
);

  localparam int D = spq_pkg::DEPTH;

  logic [spq_pkg::CNT_BITS-1:0] count_r;
  logic [spq_pkg::CNT_BITS-1:0] count_nxt;
  logic                         out_valid_r;
  logic [spq_pkg::SCORE_BITS-1:0]   out_score_r;
  logic [spq_pkg::PAYLOAD_BITS-1:0] out_payload_r;
  logic [spq_pkg::STATUS_W-1:0]     status_r;
  logic [spq_pkg::STATUS_W-1:0]     status_nxt;

  logic                accept;
  logic                full;
  logic                empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     new_entry;
  spq_pkg::entry_t     cell_entry [D];
  logic [D-1:0]        cell_lt;
  logic [D-1:0]        occ;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == spq_pkg::CNT_BITS'(D));
  assign empty       = (count_r == '0);

  assign ctrl.ins = accept && (in_ch.func == spq_pkg::FUNC_INSERT) && !full;
  assign ctrl.rem = accept && (in_ch.func == spq_pkg::FUNC_REMOVE) && !empty;

  assign new_entry.score   = in_ch.new_score;
  assign new_entry.payload = in_ch.new_payload;

  for (genvar i = 0; i < D; i++) begin : g_cell
    assign occ[i] = spq_pkg::CNT_BITS'(i) < count_r;

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ[i]),
      .new_entry   (new_entry),
      .left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
      .left_lt     ((i == 0) ? 1'b0 : cell_lt[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == D - 1) ? cell_entry[i] : cell_entry[(i == D - 1) ? i : i + 1]),
      .entry       (cell_entry[i]),
      .lt          (cell_lt[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::STATUS_DONE;
    if (ctrl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.rem) begin
      count_nxt = count_r - 1'b1;
    end
    if (in_ch.func == spq_pkg::FUNC_INSERT) begin
      if (full) begin
        status_nxt = spq_pkg::STATUS_FULL;
      end
    end else if (empty) begin
      status_nxt = spq_pkg::STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      out_score_r   <= ctrl.rem ? cell_entry[0].score : '0;
      out_payload_r <= ctrl.rem ? cell_entry[0].payload : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_score   = out_score_r;
  assign out_ch.out_payload = out_payload_r;
  assign out_ch.status      = status_r;
  assign out_ch.count       = spq_pkg::COUNT_W'(count_r);

endmodule

[rtl/core/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [spq_pkg::SCORE_BITS-1:0]   out_score,
  input logic [spq_pkg::PAYLOAD_BITS-1:0] out_payload,
  input logic [spq_pkg::STATUS_W-1:0]     status,
  input logic [spq_pkg::COUNT_W-1:0]      count
);

  localparam int D = spq_pkg::DEPTH;

  // A result waiting for its transfer stays valid and keeps its count and status.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(count) && $stable(status))
    else $error("spq: stalled result changed");

  // A stalled result must hold the input side off.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("spq: input taken while result stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(count) <= D)
    else $error("spq: count beyond depth");

  // A dropped insert can only happen with a full queue.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == spq_pkg::STATUS_FULL |-> 32'(count) == D)
    else $error("spq: insert dropped while not full");

  a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == spq_pkg::STATUS_EMPTY |->
      count == '0 && out_score == '0 && out_payload == '0)
    else $error("spq: remove on empty gave data");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_score   (out_ch.out_score),
  .out_payload (out_ch.out_payload),
  .status      (out_ch.status),
  .count       (out_ch.count)
);

[dv/sorted_priority_queue_tb.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking testbench for the sorted priority queue. A short directed
// sequence covers the field extremes, equal scores, a remove on an empty queue
// and an insert into a full one. It is followed by random segments that sweep
// the fill level between empty and full. Every result is compared field by
// field with the output of a behavioural queue. Operations are offered in
// bursts, and the result side stalls on a changing pattern.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                             func;
    logic [spq_pkg::SCORE_BITS-1:0]   score;
    logic [spq_pkg::PAYLOAD_BITS-1:0] payload;
  } queue_op_t;

  typedef struct packed {
    logic [spq_pkg::SCORE_BITS-1:0]   score;
    logic [spq_pkg::PAYLOAD_BITS-1:0] payload;
    logic [spq_pkg::STATUS_W-1:0]     status;
    logic [spq_pkg::COUNT_W-1:0]      count;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Behavioural copy of the queue, kept sorted by descending score.
  logic [spq_pkg::SCORE_BITS-1:0]   held_score [spq_pkg::DEPTH];
  logic [spq_pkg::PAYLOAD_BITS-1:0] held_payload [spq_pkg::DEPTH];
  int                               held_count = 0;

  queue_op_t     op_queue [$];
  queue_result_t due_results [$];
  queue_op_t     cur_op;

  int errors = 0;
  int n_results = 0;
  int n_inserts = 0;
  int n_dropped = 0;
  int n_removes = 0;
  int n_empty_removes = 0;
  int peak_fill = 0;
  int full_visits = 0;

  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  function automatic queue_result_t predict_queue_op(queue_op_t op);
    queue_result_t res;
    int            pos;
    res = '0;
    if (op.func == spq_pkg::FUNC_INSERT) begin
      if (held_count >= spq_pkg::DEPTH) begin
        res.status = spq_pkg::STATUS_FULL;
        n_dropped++;
      end else begin
        pos = held_count;
        for (int i = held_count - 1; i >= 0; i--) begin
          if (held_score[i] < op.score) pos = i;
        end
        for (int i = held_count; i > pos; i--) begin
          held_score[i]   = held_score[i-1];
          held_payload[i] = held_payload[i-1];
        end
        held_score[pos]   = op.score;
        held_payload[pos] = op.payload;
        held_count++;
        n_inserts++;
        if (held_count == spq_pkg::DEPTH) full_visits++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = spq_pkg::STATUS_EMPTY;
        n_empty_removes++;
      end else begin
        res.score   = held_score[0];
        res.payload = held_payload[0];
        for (int i = 1; i < held_count; i++) begin
          held_score[i-1]   = held_score[i];
          held_payload[i-1] = held_payload[i];
        end
        held_count--;
        n_removes++;
      end
    end
    if (held_count > peak_fill) peak_fill = held_count;
    res.count = spq_pkg::COUNT_W'(held_count);
    return res;
  endfunction

  task automatic push_op(logic func, logic [spq_pkg::SCORE_BITS-1:0] score,
                         logic [spq_pkg::PAYLOAD_BITS-1:0] payload);
    queue_op_t op;
    op.func    = func;
    op.score   = score;
    op.payload = payload;
    op_queue.push_back(op);
  endtask

  task automatic report_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, exp_val, act_val);
    end
  endtask

  function automatic logic [spq_pkg::SCORE_BITS-1:0] pick_score(int mode);
    logic [spq_pkg::SCORE_BITS-1:0] s;
    case (mode)
      0: begin
        s = spq_pkg::SCORE_BITS'($urandom);
      end
      1: begin
        s = spq_pkg::SCORE_BITS'($urandom_range(0, 7));
      end
      default: begin
        case ($urandom_range(0, 3))
          0: s = '0;
          1: s = '1;
          2: s = {1'b0, {(spq_pkg::SCORE_BITS-1){1'b1}}};
          default: s = {1'b1, {(spq_pkg::SCORE_BITS-1){1'b0}}};
        endcase
      end
    endcase
    return s;
  endfunction

  // Driver: offers operations in bursts and updates the prediction on each
  // transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(predict_queue_op(cur_op));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          cur_op = op_queue.pop_front();
          in_ch.func        <= cur_op.func;
          in_ch.new_score   <= cur_op.score;
          in_ch.new_payload <= cur_op.payload;
          in_ch.valid       <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 5) == 0) begin
            // An occasional long run with no gaps at all.
            burst_left = $urandom_range(60, 200);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(0, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and stalls the result side on a
  // pattern that is drawn anew at random whenever the current one runs out.
  always @(posedge clk) begin
    queue_result_t exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual score 0x%0h payload 0x%0h",
                   $time, out_ch.out_score, out_ch.out_payload);
        end else begin
          exp_res = due_results.pop_front();
          report_field("out_score", 32'(exp_res.score), 32'(out_ch.out_score));
          report_field("out_payload", 32'(exp_res.payload), 32'(out_ch.out_payload));
          report_field("status", 32'(exp_res.status), 32'(out_ch.status));
          report_field("count", 32'(exp_res.count), 32'(out_ch.count));
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 80);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= stall_tick[0];
        2: out_ch.ready <= ($urandom_range(0, 9) < 7);
        default: out_ch.ready <= (stall_tick[1:0] == 2'd0);
      endcase
    end
  end

  initial begin
    int sent;
    int seg_len;
    int insert_pct;
    int score_mode;
    in_ch.valid       = 1'b0;
    in_ch.func        = spq_pkg::FUNC_INSERT;
    in_ch.new_score   = '0;
    in_ch.new_payload = '0;
    out_ch.ready      = 1'b0;

    // Directed part.
    push_op(spq_pkg::FUNC_REMOVE, '1, '1);
    push_op(spq_pkg::FUNC_INSERT, '0, '0);
    push_op(spq_pkg::FUNC_INSERT, '1, '1);
    push_op(spq_pkg::FUNC_INSERT, 16'h8000, 16'h0001);
    push_op(spq_pkg::FUNC_INSERT, 16'h8000, 16'h0002);
    push_op(spq_pkg::FUNC_INSERT, 16'h8000, 16'h0003);
    push_op(spq_pkg::FUNC_INSERT, '0, 16'h0001);
    push_op(spq_pkg::FUNC_INSERT, 16'h7fff, 16'h5555);
    push_op(spq_pkg::FUNC_INSERT, 16'h0001, 16'haaaa);
    push_op(spq_pkg::FUNC_INSERT, '1, 16'h1234);
    for (int i = 0; i < 7; i++) begin
      push_op(spq_pkg::FUNC_INSERT, 16'(16'h2000 * i + 16'h0100), 16'(i));
    end
    push_op(spq_pkg::FUNC_INSERT, '1, '1);
    for (int i = 0; i < 5; i++) push_op(spq_pkg::FUNC_REMOVE, '0, '0);

    // Random segments, each with its own mix of inserts and removes, so the
    // fill level keeps moving between empty and full.
    sent = 0;
    while (sent < 950) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0: insert_pct = 15;
        1: insert_pct = 50;
        2: insert_pct = 85;
        default: insert_pct = 100;
      endcase
      score_mode = $urandom_range(0, 2);
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 99) < insert_pct) begin
          push_op(spq_pkg::FUNC_INSERT, pick_score(score_mode),
                  spq_pkg::PAYLOAD_BITS'($urandom));
        end else begin
          push_op(spq_pkg::FUNC_REMOVE, spq_pkg::SCORE_BITS'($urandom),
                  spq_pkg::PAYLOAD_BITS'($urandom));
        end
      end
      sent += seg_len;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (op_queue.size() > 0 || in_ch.valid || due_results.size() > 0) begin
      @(negedge clk);
    end
    repeat (10) @(posedge clk);

    $display("Checked %0d results: %0d inserts, %0d dropped on full, %0d removes, %0d on empty.",
             n_results, n_inserts, n_dropped, n_removes, n_empty_removes);
    $display("Peak fill %0d of %0d, queue filled completely %0d times.",
             peak_fill, spq_pkg::DEPTH, full_visits);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d operations and %0d results outstanding.",
             op_queue.size(), due_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
